[hw/rtl/ptc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the pressure/temperature compensation block
// no dependencies; used by the register file, the pipeline halves and the top level

package ptc_pkg;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_SENS      = 3'd0,
		REG_OFFSET    = 3'd1,
		REG_SENS_TEMP = 3'd2,
		REG_OFF_TEMP  = 3'd3,
		REG_REF_TEMP  = 3'd4,
		REG_TEMP_SLOPE = 3'd5,
		REG_AIR       = 3'd6
	} reg_idx_t;

	localparam logic [14:0] AIR_RESET = 15'd9850;

	// arithmetic constants
	localparam int TEMP_BASE = 2000;
	localparam logic signed [14:0] DEPTH_MUL = 15'sd10411;

	// saturation limits
	localparam int TEMP_LO  = -6000;
	localparam int TEMP_HI  = 12000;
	localparam int PRES_LO  = -100000;
	localparam int PRES_HI  = 600000;
	localparam int DEPTH_LO = -1300000;
	localparam int DEPTH_HI = 6200000;

	// calibration words as seen by the datapath
	typedef struct packed {
		logic [15:0] sens;
		logic [15:0] offset;
		logic [15:0] sens_temp;
		logic [15:0] off_temp;
		logic [15:0] ref_temp;
		logic [15:0] temp_slope;
		logic [14:0] air;
	} cfg_t;

	// word passed from the compensation half to the pressure/depth half
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [37:0] off;
		logic signed [35:0] sens;
		logic signed [19:0] t_out;
	} mid_t;

endpackage

[hw/rtl/ptc_in_if.sv]
`timescale 1ns / 1ps
// input channel: one raw pressure and one raw temperature conversion per word
// no dependencies

interface ptc_in_if;
	logic        valid;
	logic        ready;
	logic [23:0] pressure_raw;
	logic [23:0] temperature_raw;

	modport source (output valid, output pressure_raw, output temperature_raw, input ready);
	modport sink (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

[hw/rtl/ptc_out_if.sv]
`timescale 1ns / 1ps
// output channel: compensated temperature, pressure and depth per word
// no dependencies

interface ptc_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] temperature_centideg;
	logic signed [20:0] pressure_tenth_mbar;
	logic signed [23:0] depth_hundredths;

	modport source (output valid, output temperature_centideg, output pressure_tenth_mbar,
		output depth_hundredths, input ready);
	modport sink (input valid, input temperature_centideg, input pressure_tenth_mbar,
		input depth_hundredths, output ready);
endinterface

[hw/rtl/ptc_cfg_regs.sv]
`timescale 1ns / 1ps
// apb-style register file holding the six calibration words and the air pressure
// depends on ptc_pkg

module ptc_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0] paddr,
	input  logic [ptc_pkg::DATA_W-1:0] pwdata,
	output logic [ptc_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output ptc_pkg::cfg_t             cfg
);

	ptc_pkg::cfg_t    cfg_q;
	ptc_pkg::reg_idx_t idx;
	logic             wr;

	assign pready = 1'b1;
	assign idx    = ptc_pkg::reg_idx_t'(paddr[ptc_pkg::ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sens       <= '0;
			cfg_q.offset     <= '0;
			cfg_q.sens_temp  <= '0;
			cfg_q.off_temp   <= '0;
			cfg_q.ref_temp   <= '0;
			cfg_q.temp_slope <= '0;
			cfg_q.air        <= ptc_pkg::AIR_RESET;
		end else if (wr) begin
			unique case (idx)
				ptc_pkg::REG_SENS:       cfg_q.sens       <= pwdata[15:0];
				ptc_pkg::REG_OFFSET:     cfg_q.offset     <= pwdata[15:0];
				ptc_pkg::REG_SENS_TEMP:  cfg_q.sens_temp  <= pwdata[15:0];
				ptc_pkg::REG_OFF_TEMP:   cfg_q.off_temp   <= pwdata[15:0];
				ptc_pkg::REG_REF_TEMP:   cfg_q.ref_temp   <= pwdata[15:0];
				ptc_pkg::REG_TEMP_SLOPE: cfg_q.temp_slope <= pwdata[15:0];
				ptc_pkg::REG_AIR:        cfg_q.air        <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			ptc_pkg::REG_SENS:       prdata = {16'd0, cfg_q.sens};
			ptc_pkg::REG_OFFSET:     prdata = {16'd0, cfg_q.offset};
			ptc_pkg::REG_SENS_TEMP:  prdata = {16'd0, cfg_q.sens_temp};
			ptc_pkg::REG_OFF_TEMP:   prdata = {16'd0, cfg_q.off_temp};
			ptc_pkg::REG_REF_TEMP:   prdata = {16'd0, cfg_q.ref_temp};
			ptc_pkg::REG_TEMP_SLOPE: prdata = {16'd0, cfg_q.temp_slope};
			ptc_pkg::REG_AIR:        prdata = {17'd0, cfg_q.air};
			default:                 prdata = '0;
		endcase
	end

endmodule

[hw/rtl/ptc_front.sv]
`timescale 1ns / 1ps
// stages 1..5: dT, first-order TEMP/OFF/SENS and the second-order correction
// depends on ptc_pkg and ptc_in_if

module ptc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  ptc_pkg::cfg_t cfg,
	ptc_in_if.sink        meas,
	output logic          mid_valid,
	input  logic          mid_ready,
	output ptc_pkg::mid_t mid
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic load1, load2, load3, load4, load5;

	// stage 1
	logic [23:0]        d1_s1;
	logic signed [24:0] dt_s1;
	// stage 2
	logic [23:0]        d1_s2;
	logic signed [41:0] tprod_s2, oprod_s2, sprod_s2;
	logic [47:0]        sq_s2;
	// stage 3
	logic [23:0]        d1_s3;
	logic signed [17:0] dev_s3;
	logic signed [35:0] off1_s3, sens1_s3;
	logic [16:0]        ti_s3;
	// stage 4
	logic [23:0]        d1_s4;
	logic [33:0]        dev2_s4;
	logic               low_s4;
	logic signed [35:0] off1_s4, sens1_s4;
	logic signed [19:0] tout_s4;
	// stage 5
	ptc_pkg::mid_t      mid_s5;

	// stall chain, a stage loads when empty or when the next one loads
	assign load5      = !v_s5 || mid_ready;
	assign load4      = !v_s4 || load5;
	assign load3      = !v_s3 || load4;
	assign load2      = !v_s2 || load3;
	assign load1      = !v_s1 || load2;
	assign meas.ready = load1;
	assign mid_valid  = v_s5;
	assign mid        = mid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (load1) v_s1 <= meas.valid;
			if (load2) v_s2 <= v_s1;
			if (load3) v_s3 <= v_s2;
			if (load4) v_s4 <= v_s3;
			if (load5) v_s5 <= v_s4;
		end
	end

	// stage 1: temperature difference
	always_ff @(posedge clk) begin
		if (load1) begin
			d1_s1 <= meas.pressure_raw;
			dt_s1 <= $signed({1'b0, meas.temperature_raw}) - $signed({1'b0, cfg.ref_temp, 8'd0});
		end
	end

	// stage 2: coefficient products and dT squared
	logic signed [41:0] tprod, oprod, sprod;
	logic signed [49:0] sq;
	assign tprod = dt_s1 * $signed({1'b0, cfg.temp_slope});
	assign oprod = dt_s1 * $signed({1'b0, cfg.off_temp});
	assign sprod = dt_s1 * $signed({1'b0, cfg.sens_temp});
	assign sq    = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (load2) begin
			d1_s2    <= d1_s1;
			tprod_s2 <= tprod;
			oprod_s2 <= oprod;
			sprod_s2 <= sprod;
			sq_s2    <= sq[47:0];
		end
	end

	// stage 3: truncating shifts, first-order OFF/SENS, Ti for both ranges
	logic signed [41:0] trnd, ornd, srnd, tsh, osh, ssh;
	logic [49:0]        sq3;
	logic [16:0]        ti;
	always_comb begin
		trnd = tprod_s2 + (tprod_s2[41] ? 42'sd8388607 : 42'sd0);
		ornd = oprod_s2 + (oprod_s2[41] ? 42'sd127 : 42'sd0);
		srnd = sprod_s2 + (sprod_s2[41] ? 42'sd255 : 42'sd0);
		tsh  = trnd >>> 23;
		osh  = ornd >>> 7;
		ssh  = srnd >>> 8;
		sq3  = {2'b00, sq_s2} + {1'b0, sq_s2, 1'b0};
		// low temperature when the deviation from 20 degrees is negative
		ti   = tsh[41] ? sq3[49:33] : {5'd0, sq_s2[47:36]};
	end

	always_ff @(posedge clk) begin
		if (load3) begin
			d1_s3    <= d1_s2;
			dev_s3   <= tsh[17:0];
			off1_s3  <= $signed({4'd0, cfg.offset, 16'd0}) + $signed(osh[35:0]);
			sens1_s3 <= $signed({5'd0, cfg.sens, 15'd0}) + $signed(ssh[35:0]);
			ti_s3    <= ti;
		end
	end

	// stage 4: deviation squared, temperature result with the second-order Ti applied
	logic signed [35:0] dev_sq;
	assign dev_sq = dev_s3 * dev_s3;

	always_ff @(posedge clk) begin
		if (load4) begin
			d1_s4    <= d1_s3;
			dev2_s4  <= dev_sq[33:0];
			low_s4   <= dev_s3[17];
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			tout_s4  <= 20'(ptc_pkg::TEMP_BASE) + 20'(dev_s3) - 20'($signed({1'b0, ti_s3}));
		end
	end

	// stage 5: second-order offset and sensitivity corrections
	logic [35:0] x3;
	logic [36:0] x5;
	logic [34:0] offi;
	logic [33:0] sensi;
	always_comb begin
		x3    = {2'b00, dev2_s4} + {1'b0, dev2_s4, 1'b0};
		x5    = {3'b000, dev2_s4} + {1'b0, dev2_s4, 2'b00};
		offi  = low_s4 ? x3[35:1] : {5'd0, dev2_s4[33:4]};
		sensi = low_s4 ? x5[36:3] : 34'd0;
	end

	always_ff @(posedge clk) begin
		if (load5) begin
			mid_s5.d1    <= d1_s4;
			mid_s5.off   <= 38'(off1_s4) - $signed({3'd0, offi});
			mid_s5.sens  <= sens1_s4 - $signed({2'd0, sensi});
			mid_s5.t_out <= tout_s4;
		end
	end

endmodule

[hw/rtl/ptc_back.sv]
`timescale 1ns / 1ps
// stages 6..11: pressure product in two halves, scaling, depth and saturation
// depends on ptc_pkg and ptc_out_if

module ptc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ptc_pkg::cfg_t cfg,
	input  logic          mid_valid,
	output logic          mid_ready,
	input  ptc_pkg::mid_t mid,
	ptc_out_if.source     result
);

	logic v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic load6, load7, load8, load9, load10, load11;

	logic [41:0]        plo_s6;
	logic signed [42:0] phi_s6;
	logic signed [37:0] off_s6, off_s7;
	logic signed [19:0] t_s6, t_s7;
	logic signed [60:0] prod_s7;
	logic signed [14:0] tsat_s7, tsat_s8, tsat_s9, tsat_s10, tsat_s11;
	logic signed [40:0] x_s8;
	logic signed [27:0] p_s9;
	logic signed [28:0] pa_s9;
	logic signed [43:0] dprod_s10;
	logic signed [20:0] psat_s10, psat_s11;
	logic signed [23:0] dsat_s11;

	// stall chain
	assign load11    = !v_s11 || result.ready;
	assign load10    = !v_s10 || load11;
	assign load9     = !v_s9 || load10;
	assign load8     = !v_s8 || load9;
	assign load7     = !v_s7 || load8;
	assign load6     = !v_s6 || load7;
	assign mid_ready = load6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (load6)  v_s6  <= mid_valid;
			if (load7)  v_s7  <= v_s6;
			if (load8)  v_s8  <= v_s7;
			if (load9)  v_s9  <= v_s8;
			if (load10) v_s10 <= v_s9;
			if (load11) v_s11 <= v_s10;
		end
	end

	// stage 6: D1 times SENS as two partial products (signed high, unsigned low)
	logic [41:0]        plo;
	logic signed [42:0] phi;
	assign plo = mid.d1 * mid.sens[17:0];
	assign phi = $signed({1'b0, mid.d1}) * $signed(mid.sens[35:18]);

	always_ff @(posedge clk) begin
		if (load6) begin
			plo_s6 <= plo;
			phi_s6 <= phi;
			off_s6 <= mid.off;
			t_s6   <= mid.t_out;
		end
	end

	// stage 7: combine partial products, saturate temperature
	logic signed [14:0] tsat;
	always_comb begin
		if (t_s6 < ptc_pkg::TEMP_LO)
			tsat = 15'(ptc_pkg::TEMP_LO);
		else if (t_s6 > ptc_pkg::TEMP_HI)
			tsat = 15'(ptc_pkg::TEMP_HI);
		else
			tsat = t_s6[14:0];
	end

	always_ff @(posedge clk) begin
		if (load7) begin
			prod_s7 <= $signed({phi_s6, 18'd0}) + $signed({19'd0, plo_s6});
			off_s7  <= off_s6;
			tsat_s7 <= tsat;
		end
	end

	// stage 8: truncating divide by 2^21, subtract offset
	logic signed [60:0] prnd, psh;
	always_comb begin
		prnd = prod_s7 + (prod_s7[60] ? 61'sd2097151 : 61'sd0);
		psh  = prnd >>> 21;
	end

	always_ff @(posedge clk) begin
		if (load8) begin
			x_s8    <= 41'(psh) - 41'(off_s7);
			tsat_s8 <= tsat_s7;
		end
	end

	// stage 9: truncating divide by 2^13, subtract air pressure
	logic signed [40:0] xrnd, xsh;
	logic signed [27:0] p;
	always_comb begin
		xrnd = x_s8 + (x_s8[40] ? 41'sd8191 : 41'sd0);
		xsh  = xrnd >>> 13;
		p    = xsh[27:0];
	end

	always_ff @(posedge clk) begin
		if (load9) begin
			p_s9    <= p;
			pa_s9   <= 29'(p) - $signed({14'd0, cfg.air});
			tsat_s9 <= tsat_s8;
		end
	end

	// stage 10: depth scale product, saturate pressure
	logic signed [20:0] psat;
	logic signed [43:0] dprod;
	assign dprod = pa_s9 * ptc_pkg::DEPTH_MUL;
	always_comb begin
		if (p_s9 < ptc_pkg::PRES_LO)
			psat = 21'(ptc_pkg::PRES_LO);
		else if (p_s9 > ptc_pkg::PRES_HI)
			psat = 21'(ptc_pkg::PRES_HI);
		else
			psat = p_s9[20:0];
	end

	always_ff @(posedge clk) begin
		if (load10) begin
			dprod_s10 <= dprod;
			psat_s10  <= psat;
			tsat_s10  <= tsat_s9;
		end
	end

	// stage 11: truncating divide by 1024, saturate depth, output register
	logic signed [43:0] drnd, dsh;
	logic signed [23:0] dsat;
	always_comb begin
		drnd = dprod_s10 + (dprod_s10[43] ? 44'sd1023 : 44'sd0);
		dsh  = drnd >>> 10;
		if (dsh < ptc_pkg::DEPTH_LO)
			dsat = 24'(ptc_pkg::DEPTH_LO);
		else if (dsh > ptc_pkg::DEPTH_HI)
			dsat = 24'(ptc_pkg::DEPTH_HI);
		else
			dsat = dsh[23:0];
	end

	always_ff @(posedge clk) begin
		if (load11) begin
			dsat_s11 <= dsat;
			psat_s11 <= psat_s10;
			tsat_s11 <= tsat_s10;
		end
	end

	assign result.valid                = v_s11;
	assign result.temperature_centideg = tsat_s11;
	assign result.pressure_tenth_mbar  = psat_s11;
	assign result.depth_hundredths     = dsat_s11;

endmodule

[hw/rtl/pressure_temperature_compensation_top.sv]
`timescale 1ns / 1ps
// Pressure sensor compensation with second-order temperature correction.
// Channel meas (valid/ready) takes one word: raw 24-bit pressure and raw
// 24-bit temperature conversions. Channel result (valid/ready) gives one word
// per input: temperature in 0.01 degC, pressure in 0.1 mbar and depth in
// hundredths, each saturated to its range.
// The APB-style port holds the six calibration words at byte addresses 0..20
// and the surface air pressure at 24; pready is always high, writes land at
// the access cycle. Program it only while no word is in flight.
// One meas word is accepted every cycle while result is not stalled. The
// pipeline is 11 register stages: dT, coefficient products, first-order
// terms, deviation square, second-order terms, split pressure product,
// product sum, two scaling stages, depth product, output.
// When result is stalled each stage holds its word and empty stages still
// fill, so meas keeps accepting until the pipeline is full.
// Reset (arst_n low) empties the pipeline and restores register defaults:
// calibration words zero, air pressure 9850.
// depends on ptc_pkg, ptc_in_if, ptc_out_if, ptc_cfg_regs, ptc_front, ptc_back

module pressure_temperature_compensation_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0] paddr,
	input  logic [ptc_pkg::DATA_W-1:0] pwdata,
	output logic [ptc_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	ptc_in_if.sink                    meas,
	ptc_out_if.source                 result
);

	ptc_pkg::cfg_t cfg;
	ptc_pkg::mid_t mid;
	logic          mid_valid;
	logic          mid_ready;

	// calibration registers
	ptc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// compensation stages
	ptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.meas      (meas),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	// pressure, depth and saturation stages
	ptc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.result    (result)
	);

endmodule
